// ===== design/ttce_pkg.sv =====
// shared types and constants for the text terminal cursor engine
// no dependencies
`default_nettype none

package ttce_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 4;
  localparam int CELL_W = CHAR_W + 2 * CLR_W;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEFAULT_COLS = 80;
  localparam int DEFAULT_ROWS = 25;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd1;

  localparam logic [CLR_W-1:0] BG_RESET = 4'd0;
  localparam logic [CLR_W-1:0] FG_RESET = 4'd7;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  localparam int TAB_STEP = 8;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr_cell;
    logic             scroll;
  } cursor_upd_t;

endpackage

`default_nettype wire

// ===== design/ttce_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module ttce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ttce_cursor.sv =====
// next cursor position for one put byte
// depends on ttce_pkg
`default_nettype none

module ttce_cursor #(
  parameter int COLS = ttce_pkg::DEFAULT_COLS,
  parameter int ROWS = ttce_pkg::DEFAULT_ROWS
) (
  input  wire logic [ttce_pkg::COL_W-1:0]  col,
  input  wire logic [ttce_pkg::ROW_W-1:0]  row,
  input  wire logic [ttce_pkg::CHAR_W-1:0] ch,
  output ttce_pkg::cursor_upd_t            upd
);

  localparam logic [ttce_pkg::COL_W-1:0] COL_LAST = ttce_pkg::COL_W'(COLS - 1);
  localparam logic [ttce_pkg::ROW_W-1:0] ROW_LAST = ttce_pkg::ROW_W'(ROWS - 1);

  logic [ttce_pkg::COL_W:0] tab_pos;
  logic                     adv_row;

  always_comb begin
    tab_pos = ({1'b0, col} + (ttce_pkg::COL_W+1)'(ttce_pkg::TAB_STEP))
              & ~(ttce_pkg::COL_W+1)'(ttce_pkg::TAB_STEP - 1);
    upd.col     = col;
    upd.row     = row;
    upd.wr_cell = 1'b0;
    upd.scroll  = 1'b0;
    adv_row     = 1'b0;
    case (ch) inside
      ttce_pkg::CH_BS: begin
        if (col != '0) begin
          upd.col = col - 1'b1;
        end
      end
      ttce_pkg::CH_TAB: begin
        if (tab_pos > {1'b0, COL_LAST}) begin
          upd.col = COL_LAST;
        end else begin
          upd.col = tab_pos[ttce_pkg::COL_W-1:0];
        end
      end
      ttce_pkg::CH_LF: begin
        upd.col = '0;
        adv_row = 1'b1;
      end
      ttce_pkg::CH_CR: begin
        upd.col = '0;
      end
      [ttce_pkg::CH_SPACE:ttce_pkg::CH_DEL]: begin
        upd.wr_cell = 1'b1;
        if (col == COL_LAST) begin
          upd.col = '0;
          adv_row = 1'b1;
        end else begin
          upd.col = col + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (adv_row) begin
      if (row == ROW_LAST) begin
        upd.col    = '0;
        upd.row    = ROW_LAST;
        upd.scroll = 1'b1;
      end else begin
        upd.row = row + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ttce_ctrl.sv =====
// item sequencer: screen store addressing, clearing sweeps, scroll by row offset
// depends on ttce_pkg; drives ttce_ram and uses ttce_cursor results
`default_nettype none

module ttce_ctrl #(
  parameter int COLS = ttce_pkg::DEFAULT_COLS,
  parameter int ROWS = ttce_pkg::DEFAULT_ROWS,
  parameter int CW   = $clog2(COLS),
  parameter int RW   = $clog2(ROWS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ttce_pkg::OP_W-1:0]    operation,
  input  wire logic [ttce_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [ttce_pkg::COL_W-1:0]   read_col,
  input  wire logic [ttce_pkg::ROW_W-1:0]   read_row,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [ttce_pkg::COL_W-1:0]   cursor_col,
  output logic      [ttce_pkg::ROW_W-1:0]   cursor_row,
  output logic                              scrolled,
  output logic      [ttce_pkg::CHAR_W-1:0]  cell_char,
  output logic      [ttce_pkg::CLR_W-1:0]   cell_fg,
  output logic      [ttce_pkg::CLR_W-1:0]   cell_bg,
  input  wire logic [ttce_pkg::CLR_W-1:0]   bg_colour,
  input  wire logic [ttce_pkg::CLR_W-1:0]   fg_colour,
  output logic      [ttce_pkg::COL_W-1:0]   cur_col,
  output logic      [ttce_pkg::ROW_W-1:0]   cur_row,
  output logic      [ttce_pkg::CHAR_W-1:0]  cur_char,
  input  wire ttce_pkg::cursor_upd_t        upd,
  output logic                              ram_we,
  output logic      [CW+RW-1:0]             ram_waddr,
  output logic      [ttce_pkg::CELL_W-1:0]  ram_wdata,
  output logic      [CW+RW-1:0]             ram_raddr,
  input  wire logic [ttce_pkg::CELL_W-1:0]  ram_rdata
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_DONE
  } state_t;

  localparam logic [RW:0]   ROWS_W   = (RW+1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

  state_t                          state;
  logic   [ttce_pkg::OP_W-1:0]     op_q;
  logic   [ttce_pkg::COL_W-1:0]    rcol_q;
  logic   [ttce_pkg::ROW_W-1:0]    rrow_q;
  logic   [RW-1:0]                 top;
  logic   [RW-1:0]                 sweep_row;
  logic   [CW-1:0]                 sweep_col;
  logic                            sweep_all;
  logic                            boot;
  logic                            scr_flag;
  logic   [ttce_pkg::CELL_W-1:0]   cell_q;

  logic   [RW-1:0]                 map_row;
  logic   [RW:0]                   row_sum;
  logic   [RW-1:0]                 phys_row;
  logic                            rd_in_range;
  logic   [ttce_pkg::CELL_W-1:0]   blank;

  assign in_ready = (state == S_IDLE);
  assign blank    = {bg_colour, fg_colour, ttce_pkg::CH_SPACE};

  always_comb begin
    map_row = (op_q == ttce_pkg::OP_READ) ? rrow_q[RW-1:0] : cur_row[RW-1:0];
    row_sum = {1'b0, map_row} + {1'b0, top};
    if (row_sum >= ROWS_W) begin
      phys_row = RW'(row_sum - ROWS_W);
    end else begin
      phys_row = row_sum[RW-1:0];
    end
    rd_in_range = ({1'b0, rcol_q} < (ttce_pkg::COL_W+1)'(COLS))
                  && ({1'b0, rrow_q} < (ttce_pkg::ROW_W+1)'(ROWS));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {phys_row, cur_col[CW-1:0]};
    ram_wdata = {bg_colour, fg_colour, cur_char};
    ram_raddr = {phys_row, rcol_q[CW-1:0]};
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = {sweep_row, sweep_col};
      ram_wdata = blank;
    end else if (state == S_EXEC && op_q == ttce_pkg::OP_PUT && upd.wr_cell) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      out_valid <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      sweep_row <= '0;
      sweep_col <= '0;
      sweep_all <= 1'b1;
      boot      <= 1'b1;
      scr_flag  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_col == COL_LAST) begin
            sweep_col <= '0;
            if (sweep_all && sweep_row != ROW_LAST) begin
              sweep_row <= sweep_row + 1'b1;
            end else begin
              boot  <= 1'b0;
              state <= boot ? S_IDLE : S_DONE;
            end
          end else begin
            sweep_col <= sweep_col + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= operation;
            cur_char <= char_code;
            rcol_q   <= read_col;
            rrow_q   <= read_row;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          scr_flag <= (op_q == ttce_pkg::OP_PUT) && upd.scroll;
          cell_q   <= '0;
          case (op_q)
            ttce_pkg::OP_PUT: begin
              cur_col  <= upd.col;
              cur_row  <= upd.row;
              if (upd.scroll) begin
                // old top row becomes the new bottom row
                top       <= (top == ROW_LAST) ? '0 : top + 1'b1;
                sweep_row <= top;
                sweep_col <= '0;
                sweep_all <= 1'b0;
                state     <= S_SWEEP;
              end else begin
                state <= S_DONE;
              end
            end
            ttce_pkg::OP_CLEAR: begin
              cur_col   <= '0;
              cur_row   <= '0;
              top       <= '0;
              sweep_row <= '0;
              sweep_col <= '0;
              sweep_all <= 1'b1;
              state     <= S_SWEEP;
            end
            ttce_pkg::OP_READ: begin
              state <= S_RDWAIT;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RDWAIT: begin
          cell_q <= rd_in_range ? ram_rdata : '0;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            cursor_col <= cur_col;
            cursor_row <= cur_row;
            scrolled   <= scr_flag;
            cell_char  <= cell_q[ttce_pkg::CHAR_W-1:0];
            cell_fg    <= cell_q[ttce_pkg::CHAR_W +: ttce_pkg::CLR_W];
            cell_bg    <= cell_q[ttce_pkg::CHAR_W+ttce_pkg::CLR_W +: ttce_pkg::CLR_W];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/text_terminal_cursor_engine_core.sv =====
// top level of the text terminal cursor engine: config registers and assertions
// depends on ttce_pkg, ttce_ram, ttce_cursor, ttce_ctrl
`default_nettype none

// Character-cell terminal with a cursor. The screen lives in one synchronous
// RAM of 2^(clog2(ROWS)+clog2(COLS)) cells; scrolling moves a top-row offset
// instead of copying, so only the new bottom row is rewritten. Items are
// handled one at a time by the sequencer: put and no-op items pass through
// the execute and done states, a read adds a wait state for the registered
// RAM read, a put that scrolls first sweeps blanks over the bottom row, and
// clear sweeps every cell, one cell written per cycle. After reset a
// clearing pass over all ROWS*COLS cells runs with in_ready low.
// The output register lets the next item be accepted while a result waits.
// Configuration writes are always taken and apply to later writes and blanks.
module text_terminal_cursor_engine_core #(
  parameter int COLS = ttce_pkg::DEFAULT_COLS,
  parameter int ROWS = ttce_pkg::DEFAULT_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ttce_pkg::OP_W-1:0]       operation,
  input  wire logic [ttce_pkg::CHAR_W-1:0]     char_code,
  input  wire logic [ttce_pkg::COL_W-1:0]      read_col,
  input  wire logic [ttce_pkg::ROW_W-1:0]      read_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [ttce_pkg::COL_W-1:0]      cursor_col,
  output logic      [ttce_pkg::ROW_W-1:0]      cursor_row,
  output logic                                 scrolled,
  output logic      [ttce_pkg::CHAR_W-1:0]     cell_char,
  output logic      [ttce_pkg::CLR_W-1:0]      cell_fg,
  output logic      [ttce_pkg::CLR_W-1:0]      cell_bg,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ttce_pkg::CLR_W-1:0]      cfg_data
);

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);

  logic [ttce_pkg::CLR_W-1:0]   bg_colour;
  logic [ttce_pkg::CLR_W-1:0]   fg_colour;
  logic [ttce_pkg::COL_W-1:0]   cur_col;
  logic [ttce_pkg::ROW_W-1:0]   cur_row;
  logic [ttce_pkg::CHAR_W-1:0]  cur_char;
  ttce_pkg::cursor_upd_t        upd;
  logic                         ram_we;
  logic [CW+RW-1:0]             ram_waddr;
  logic [ttce_pkg::CELL_W-1:0]  ram_wdata;
  logic [CW+RW-1:0]             ram_raddr;
  logic [ttce_pkg::CELL_W-1:0]  ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_colour <= ttce_pkg::BG_RESET;
      fg_colour <= ttce_pkg::FG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttce_pkg::REG_BG: bg_colour <= cfg_data;
        ttce_pkg::REG_FG: fg_colour <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ttce_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .col (cur_col),
    .row (cur_row),
    .ch  (cur_char),
    .upd (upd)
  );

  ttce_ram #(
    .WIDTH (ttce_pkg::CELL_W),
    .DEPTH (2 ** (CW + RW))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttce_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS),
    .CW   (CW),
    .RW   (RW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .char_code  (char_code),
    .read_col   (read_col),
    .read_row   (read_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled),
    .cell_char  (cell_char),
    .cell_fg    (cell_fg),
    .cell_bg    (cell_bg),
    .bg_colour  (bg_colour),
    .fg_colour  (fg_colour),
    .cur_col    (cur_col),
    .cur_row    (cur_row),
    .cur_char   (cur_char),
    .upd        (upd),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  a_boot_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input accepted during clearing pass");

  a_no_write_while_ready: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !in_ready)
    else $error("screen write while idle");

  a_cursor_in_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, cursor_col} < (ttce_pkg::COL_W+1)'(COLS))
                  && ({1'b0, cursor_row} < (ttce_pkg::ROW_W+1)'(ROWS)))
    else $error("cursor out of bounds");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_col == '0)
                                && (cursor_row == ttce_pkg::ROW_W'(ROWS - 1)))
    else $error("scroll left cursor off the bottom line start");

endmodule

`default_nettype wire
